// ----- rtl/cgi_pkg.sv -----
package cgi_pkg;

    localparam int MAX_POINTS_DEF = 6;

    localparam int POINT_W     = 40;
    localparam int KEY_W       = 8;
    localparam int CHAN_W      = 8;
    localparam int COUNT_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int LIFE_W      = 17;
    localparam int TOTAL_W     = 16;

    localparam int PCT_W   = 15;
    localparam int PROD_W  = 31;
    localparam int DIV_W   = 16;
    localparam int STEP_W  = 4;
    localparam int MIX_W   = 24;

    localparam logic [PCT_W-1:0]  PCT_SCALE  = 15'd25600;
    localparam logic [STEP_W-1:0] PCT_STEPS  = 4'd15;
    localparam logic [STEP_W-1:0] CHAN_STEPS = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_0     = 3'd1;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem0;
        logic [DIV_W-1:0]  tail;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_resp_t;

endpackage

// ----- rtl/color_gradient_interpolator.sv -----
// Maps a particle's elapsed life to an RGBA color over a table of up to
// MAX_POINTS (six by default) gradient points. A request is taken when start
// is high and busy is low; a non-living particle is dropped with no result.
// Each result is shown for exactly one cycle with done high and cannot be
// held off, so the receiver must take it then. The percentage uses one
// 15-step pass of the shared serial divider and each of the four channels
// an 8-step pass. Equal bracketing keys finish after the scan, and an
// expired particle or an empty table skips to the result. The user must
// write configuration only while busy is low; the block does not enforce it.
module color_gradient_interpolator
    import cgi_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [LIFE_W-1:0]      life_left,
    input  logic        [TOTAL_W-1:0]     life_total,
    input  logic                          living,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic        [CFG_INDEX_W-1:0] cfg_index,
    input  logic        [POINT_W-1:0]     cfg_data,
    output logic                          done,
    output logic        [CHAN_W-1:0]      red,
    output logic        [CHAN_W-1:0]      green,
    output logic        [CHAN_W-1:0]      blue,
    output logic        [CHAN_W-1:0]      alpha
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_POINTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PMUL,
        S_PSTART,
        S_PWAIT,
        S_SCAN,
        S_PREP,
        S_CMUL_A,
        S_CMUL_B,
        S_CSTART,
        S_CWAIT,
        S_OUT
    } state_t;

    logic [COUNT_W-1:0] point_count_reg;
    logic [POINT_W-1:0] point_reg [MAX_POINTS];

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [1:0]         chan_reg, chan_next;
    logic [TOTAL_W-1:0] diff_reg, diff_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PCT_W-1:0]   pct_reg, pct_next;
    logic               pct_neg_reg, pct_neg_next;
    logic [POINT_W-1:0] last_pt_reg, last_pt_next;
    logic [POINT_W-1:0] next_pt_reg, next_pt_next;
    logic [DIV_W-1:0]   den_reg, den_next;
    logic [DIV_W-1:0]   num_reg, num_next;
    logic [DIV_W-1:0]   dn_reg, dn_next;
    logic [MIX_W-1:0]   mix_reg, mix_next;
    logic [CHAN_W-1:0]  color_reg [4];
    logic [CHAN_W-1:0]  color_next [4];

    logic [COUNT_W-1:0] n_eff;
    logic [POINT_W-1:0] pt;
    logic               key_hit;
    logic               at_end;
    logic [KEY_W-1:0]   lk;
    logic [KEY_W-1:0]   nk;
    logic [DIV_W-1:0]   den_calc;
    logic [DIV_W-1:0]   num_calc;
    logic [CHAN_W-1:0]  chan_a;
    logic [CHAN_W-1:0]  chan_b;
    div_req_t           div_req;
    div_resp_t          div_resp;

    function automatic logic [CHAN_W-1:0] chan_of(input logic [POINT_W-1:0] p,
                                                  input logic [1:0] c);
        logic [CHAN_W-1:0] v;
        case (c)
            2'd0:    v = p[31:24];
            2'd1:    v = p[23:16];
            2'd2:    v = p[15:8];
            default: v = p[7:0];
        endcase
        return v;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            for (int j = 0; j < MAX_POINTS; j++)
            begin
                point_reg[j] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_POINT_COUNT)
            begin
                point_count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int j = 0; j < MAX_POINTS; j++)
            begin
                if (cfg_index == CFG_INDEX_W'(REG_POINT_0 + CFG_INDEX_W'(j)))
                begin
                    point_reg[j] <= cfg_data;
                end
            end
        end
    end

    assign n_eff = (point_count_reg > MAX_CNT) ? MAX_CNT : point_count_reg;

    assign pt       = point_reg[idx_reg];
    assign key_hit  = pct_neg_reg || ({pt[POINT_W-1 -: KEY_W], 8'h00} >= {1'b0, pct_reg});
    assign at_end   = (COUNT_W'(idx_reg) == (n_eff - 1'b1));
    assign lk       = last_pt_reg[POINT_W-1 -: KEY_W];
    assign nk       = next_pt_reg[POINT_W-1 -: KEY_W];
    assign den_calc = {KEY_W'(nk - lk), 8'h00};
    assign num_calc = DIV_W'({1'b0, pct_reg} - {lk, 8'h00});
    assign chan_a   = chan_of(last_pt_reg, chan_reg);
    assign chan_b   = chan_of(next_pt_reg, chan_reg);

    always_comb
    begin
        div_req.start = (state_reg == S_PSTART) || (state_reg == S_CSTART);
        if (state_reg == S_CSTART)
        begin
            div_req.rem0  = mix_reg[MIX_W-1:CHAN_W];
            div_req.tail  = {mix_reg[CHAN_W-1:0], 8'h00};
            div_req.steps = CHAN_STEPS;
            div_req.den   = den_reg;
        end
        else
        begin
            div_req.rem0  = prod_reg[PROD_W-1:PCT_W];
            div_req.tail  = {prod_reg[PCT_W-1:0], 1'b0};
            div_req.steps = PCT_STEPS;
            div_req.den   = total_reg;
        end
    end

    cgi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        chan_next    = chan_reg;
        diff_next    = diff_reg;
        total_next   = total_reg;
        prod_next    = prod_reg;
        pct_next     = pct_reg;
        pct_neg_next = pct_neg_reg;
        last_pt_next = last_pt_reg;
        next_pt_next = next_pt_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        dn_next      = dn_reg;
        mix_next     = mix_reg;
        for (int c = 0; c < 4; c++)
        begin
            color_next[c] = color_reg[c];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start && living)
                begin
                    idx_next     = '0;
                    total_next   = life_total;
                    pct_next     = '0;
                    pct_neg_next = 1'b0;
                    if ((n_eff == '0) || life_left[LIFE_W-1])
                    begin
                        color_next[0] = '0;
                        color_next[1] = '0;
                        color_next[2] = '0;
                        color_next[3] = '1;
                        state_next    = S_OUT;
                    end
                    else if (life_total == '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (life_left[TOTAL_W-1:0] > life_total)
                    begin
                        pct_neg_next = 1'b1;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        diff_next  = life_total - life_left[TOTAL_W-1:0];
                        state_next = S_PMUL;
                    end
                end
            end
            S_PMUL:
            begin
                prod_next  = PROD_W'(diff_reg) * PROD_W'(PCT_SCALE);
                state_next = S_PSTART;
            end
            S_PSTART:
            begin
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (div_resp.done)
                begin
                    pct_next   = div_resp.quo[PCT_W-1:0];
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (key_hit)
                begin
                    next_pt_next = pt;
                    if (idx_reg == '0)
                    begin
                        last_pt_next = pt;
                    end
                    state_next = S_PREP;
                end
                else
                begin
                    last_pt_next = pt;
                    if (at_end)
                    begin
                        next_pt_next = pt;
                        state_next   = S_PREP;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_PREP:
            begin
                if (lk == nk)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        color_next[c] = chan_of(last_pt_reg, 2'(c));
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    den_next   = den_calc;
                    num_next   = num_calc;
                    dn_next    = den_calc - num_calc;
                    chan_next  = '0;
                    state_next = S_CMUL_A;
                end
            end
            S_CMUL_A:
            begin
                mix_next   = MIX_W'(chan_a) * MIX_W'(dn_reg);
                state_next = S_CMUL_B;
            end
            S_CMUL_B:
            begin
                mix_next   = mix_reg + MIX_W'(chan_b) * MIX_W'(num_reg);
                state_next = S_CSTART;
            end
            S_CSTART:
            begin
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (div_resp.done)
                begin
                    color_next[chan_reg] = div_resp.quo[CHAN_W-1:0];
                    if (chan_reg == 2'd3)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 1'b1;
                        state_next = S_CMUL_A;
                    end
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            chan_reg    <= '0;
            diff_reg    <= '0;
            total_reg   <= '0;
            prod_reg    <= '0;
            pct_reg     <= '0;
            pct_neg_reg <= 1'b0;
            last_pt_reg <= '0;
            next_pt_reg <= '0;
            den_reg     <= '0;
            num_reg     <= '0;
            dn_reg      <= '0;
            mix_reg     <= '0;
            for (int c = 0; c < 4; c++)
            begin
                color_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            chan_reg    <= chan_next;
            diff_reg    <= diff_next;
            total_reg   <= total_next;
            prod_reg    <= prod_next;
            pct_reg     <= pct_next;
            pct_neg_reg <= pct_neg_next;
            last_pt_reg <= last_pt_next;
            next_pt_reg <= next_pt_next;
            den_reg     <= den_next;
            num_reg     <= num_next;
            dn_reg      <= dn_next;
            mix_reg     <= mix_next;
            for (int c = 0; c < 4; c++)
            begin
                color_reg[c] <= color_next[c];
            end
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = (state_reg == S_OUT);
    assign red   = color_reg[0];
    assign green = color_reg[1];
    assign blue  = color_reg[2];
    assign alpha = color_reg[3];

endmodule

// ----- rtl/cgi_div.sv -----
module cgi_div
    import cgi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_resp_t resp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  tail_reg, tail_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W:0]    trial;
    logic              ge;

    // One restoring step per cycle; the caller guarantees rem0 is below den.
    always_comb
    begin
        trial     = {rem_reg, tail_reg[DIV_W-1]};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        tail_next = tail_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem0;
            tail_next = req.tail;
            den_next  = req.den;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            tail_next = {tail_reg[DIV_W-2:0], 1'b0};
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            tail_reg <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            tail_reg <= tail_next;
            den_reg  <= den_next;
            quo_reg  <= quo_next;
        end
    end

    assign resp.done = done_reg;
    assign resp.quo  = quo_reg;

endmodule

// ----- tb/tb.sv -----
module tb
    import cgi_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } color_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [LIFE_W-1:0]      life_left;
    logic        [TOTAL_W-1:0]     life_total;
    logic                          living;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic        [CFG_INDEX_W-1:0] cfg_index;
    logic        [POINT_W-1:0]     cfg_data;
    logic                          done;
    logic        [CHAN_W-1:0]      red;
    logic        [CHAN_W-1:0]      green;
    logic        [CHAN_W-1:0]      blue;
    logic        [CHAN_W-1:0]      alpha;

    logic [COUNT_W-1:0] active_points;
    logic [POINT_W-1:0] gradient [MAX_POINTS_DEF];
    logic [POINT_W-1:0] staged_points [MAX_POINTS_DEF];
    color_t             expected_colors [$];
    int                 idle_pct;
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;

    color_gradient_interpolator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .life_left  (life_left),
        .life_total (life_total),
        .living     (living),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic color_t predict_color(logic signed [LIFE_W-1:0] life,
                                             logic [TOTAL_W-1:0] total);
        color_t       c;
        int           n;
        int           li;
        int           ti;
        int           pct;
        int           i;
        int           last;
        int           nxt;
        int           lk;
        int           nk;
        longint       num;
        longint       den;
        longint       a;
        longint       b;
        longint       v;
        logic [POINT_W-1:0] lp;
        logic [POINT_W-1:0] np;
        logic [4*CHAN_W-1:0] packed_color;
        n = (active_points > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(active_points);
        if (n == 0 || life < 0)
        begin
            c = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'hFF};
            return c;
        end
        li = int'(life);
        ti = int'(total);
        if (ti == 0)
            pct = 0;
        else if (li > ti)
            pct = -1;
        else
            pct = (25600 * (ti - li)) / ti;
        last = 0;
        for (i = 0; i < n; i++)
        begin
            if (int'(gradient[i][39:32]) * 256 >= pct)
                break;
            last = i;
        end
        nxt = (i < n) ? i : last;
        lp = gradient[last];
        np = gradient[nxt];
        lk = int'(lp[39:32]);
        nk = int'(np[39:32]);
        if (lk == nk)
        begin
            c = color_t'(lp[31:0]);
            return c;
        end
        num = longint'(pct) - longint'(lk) * 256;
        den = (longint'(nk) - longint'(lk)) * 256;
        for (int k = 0; k < 4; k++)
        begin
            a = longint'(lp[31 - 8 * k -: 8]);
            b = longint'(np[31 - 8 * k -: 8]);
            v = a * den + (b - a) * num;
            if (v < 0)
                v = 0;
            v = v / den;
            if (v > 255)
                v = 255;
            packed_color[31 - 8 * k -: 8] = v[7:0];
        end
        c = color_t'(packed_color);
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [POINT_W-1:0] data);
        while ($urandom_range(99) < idle_pct)
        begin
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_POINT_COUNT)
            active_points = data[COUNT_W-1:0];
        else
            gradient[index - REG_POINT_0] = data;
    endtask

    task automatic load_gradient(input int count);
        write_reg(REG_POINT_COUNT, POINT_W'(count));
        for (int k = 0; k < MAX_POINTS_DEF; k++)
            write_reg(REG_POINT_0 + CFG_INDEX_W'(k), staged_points[k]);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_particle(input logic signed [LIFE_W-1:0] life,
                                 input logic [TOTAL_W-1:0] total,
                                 input logic alive);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        life_left  <= life;
        life_total <= total;
        living     <= alive;
        do
            @(posedge clk);
        while (busy);
        if (alive)
            expected_colors.push_back(predict_color(life, total));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_particle(17'sd50, 16'd100, 1'b1);
        send_particle(17'sd0, 16'd1, 1'b1);
        send_particle(-17'sd1, 16'd65535, 1'b1);
        send_particle(17'sd10, 16'd100, 1'b0);
        settle();
    endtask

    task automatic test_directed_points();
        staged_points[0] = {8'd0,   32'h00000000};
        staged_points[1] = {8'd25,  32'hFFFFFFFF};
        staged_points[2] = {8'd25,  32'h80402010};
        staged_points[3] = {8'd50,  32'h00FF00FF};
        staged_points[4] = {8'd75,  32'hFF00FF00};
        staged_points[5] = {8'd100, 32'h12345678};
        load_gradient(6);
        send_particle(17'sd100, 16'd100, 1'b1);
        send_particle(17'sd0, 16'd100, 1'b1);
        send_particle(17'sd75, 16'd100, 1'b1);
        send_particle(17'sd60, 16'd100, 1'b1);
        send_particle(17'sd12345, 16'd65535, 1'b1);
        send_particle(17'sd65535, 16'd65535, 1'b1);
        send_particle(17'sd0, 16'd65535, 1'b1);
        send_particle(17'sd1, 16'd3, 1'b1);
        send_particle(17'sd65535, 16'd10, 1'b1);
        send_particle(-17'sd65536, 16'd100, 1'b1);
        send_particle(-17'sd1, 16'd1, 1'b1);
        send_particle(17'sd50, 16'd100, 1'b0);
        settle();

        staged_points[0] = {8'd10, 32'hA0B0C0D0};
        staged_points[1] = {8'd30, 32'h01020304};
        staged_points[2] = {8'd60, 32'hFEDCBA98};
        load_gradient(3);
        send_particle(17'sd0, 16'd100, 1'b1);
        send_particle(17'sd95, 16'd100, 1'b1);
        send_particle(17'sd3, 16'd7, 1'b1);
        settle();

        staged_points[0] = {8'd80,  32'h11223344};
        staged_points[1] = {8'd20,  32'hFF00FF00};
        staged_points[2] = {8'd200, 32'h00FF00FF};
        staged_points[3] = {8'd5,   32'h55667788};
        staged_points[4] = {8'd255, 32'hFFFFFFFF};
        staged_points[5] = {8'd0,   32'h00000000};
        load_gradient(6);
        send_particle(17'sd10, 16'd100, 1'b1);
        send_particle(17'sd0, 16'd100, 1'b1);
        send_particle(17'sd4321, 16'd9999, 1'b1);
        settle();

        staged_points[0] = {8'd255, 32'hCAFEF00D};
        load_gradient(1);
        send_particle(17'sd1, 16'd2, 1'b1);
        send_particle(17'sd0, 16'd65535, 1'b1);
        settle();
    endtask

    task automatic test_random_tables();
        int                    count;
        int                    keys [$];
        logic [TOTAL_W-1:0]    total;
        logic signed [LIFE_W-1:0] life;
        int                    r;
        for (int phase = 0; phase < 9; phase++)
        begin
            idle_pct = (phase == 4) ? 0 : 36;
            case (phase)
                0: count = 6;
                1: count = 0;
                2: count = 1;
                default: count = $urandom_range(0, 6);
            endcase
            keys.delete();
            for (int k = 0; k < MAX_POINTS_DEF; k++)
            begin
                if (k > 0 && $urandom_range(99) < 25)
                    keys.push_back(keys[k - 1]);
                else if ($urandom_range(99) < 85)
                    keys.push_back($urandom_range(0, 100));
                else
                    keys.push_back($urandom_range(0, 255));
            end
            if (phase != 6)
                keys.sort();
            for (int k = 0; k < MAX_POINTS_DEF; k++)
            begin
                r = $urandom_range(99);
                staged_points[k] = {8'(keys[k]),
                                    (r < 10) ? 32'hFFFFFFFF :
                                    (r < 20) ? 32'h00000000 : 32'($urandom)};
            end
            load_gradient(count);
            for (int n = 0; n < 50; n++)
            begin
                r = $urandom_range(99);
                if (r < 15)
                    total = TOTAL_W'($urandom_range(1, 8));
                else if (r < 30)
                    total = 16'd100;
                else if (r < 40)
                    total = 16'd65535;
                else
                    total = TOTAL_W'($urandom_range(1, 65535));
                r = $urandom_range(99);
                if (r < 8)
                    life = -LIFE_W'($urandom_range(1, 65536));
                else if (r < 15)
                    life = LIFE_W'($urandom_range(int'(total), 65535));
                else if (r < 20)
                    life = LIFE_W'($urandom);
                else
                    life = LIFE_W'($urandom_range(0, int'(total)));
                send_particle(life, total, $urandom_range(99) < 88);
            end
            settle();
        end
    endtask

    always @(posedge clk)
    begin
        color_t want;
        if (rst_n && done)
        begin
            if (expected_colors.size() == 0)
            begin
                $error("unexpected result: red %0d green %0d blue %0d alpha %0d",
                       red, green, blue, alpha);
                mismatch_count++;
            end
            else
            begin
                want = expected_colors.pop_front();
                if (red !== want.red)
                begin
                    $error("red: expected %0d, actual %0d", want.red, red);
                    mismatch_count++;
                end
                if (green !== want.green)
                begin
                    $error("green: expected %0d, actual %0d", want.green, green);
                    mismatch_count++;
                end
                if (blue !== want.blue)
                begin
                    $error("blue: expected %0d, actual %0d", want.blue, blue);
                    mismatch_count++;
                end
                if (alpha !== want.alpha)
                begin
                    $error("alpha: expected %0d, actual %0d", want.alpha, alpha);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     expected_colors.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        life_left      = '0;
        life_total     = '0;
        living         = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        idle_pct       = 36;
        active_points  = '0;
        for (int k = 0; k < MAX_POINTS_DEF; k++)
        begin
            gradient[k]      = '0;
            staged_points[k] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_directed_points();
        test_random_tables();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
